[design/binary_mask_centroid_core_defines.svh]
// Assertion macros shared by the centroid core's checker.
// No dependencies; take it in with `include of the bare file name.
`ifndef BINARY_MASK_CENTROID_CORE_DEFINES_SVH
`define BINARY_MASK_CENTROID_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define BMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("centroid core check failed");

// Checks that cons holds in the cycle after ante.
`define BMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("centroid core check failed");

`endif

[design/bmc_pkg.sv]
// Shared types and constants for the binary mask centroid core.
// No dependencies; imported by every module of the core.
package bmc_pkg;

    localparam int POS_W    = 11;
    localparam int SUM_W    = 33;
    localparam int COUNT_W  = 23;
    localparam int SIZE_W   = 12;
    localparam int PIXEL_W  = 8;
    localparam int COORD_W  = 11;
    localparam int REM_W    = COUNT_W + 1;
    localparam int STEP_W   = 6;

    localparam logic [PIXEL_W-1:0] OBJECT_VALUE = 8'd255;
    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 12'd480;

    // One quotient bit is produced per step.
    localparam logic [STEP_W-1:0]  DIV_LAST_STEP = STEP_W'(SUM_W - 1);

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0]   column_sum;
        logic [SUM_W-1:0]   row_sum;
        logic [COUNT_W-1:0] pixel_count;
    } frame_sums_t;

    typedef struct packed {
        logic        valid;
        frame_sums_t sums;
    } frame_entry_t;

endpackage

[design/bmc_front.sv]
// Front end of the centroid core: frame counters, moment accumulators, config.
// Depends on bmc_pkg; pushes finished frame sums into bmc_queue.
module bmc_front import bmc_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIXEL_W-1:0]  s_pixel,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [SIZE_W-1:0]   cfg_data,
    input  logic                queue_full,
    output frame_entry_t        push
);

    logic [SIZE_W-1:0]  frame_width_reg;
    logic [SIZE_W-1:0]  frame_height_reg;
    logic [POS_W-1:0]   column_reg;
    logic [POS_W-1:0]   row_reg;
    logic [SUM_W-1:0]   column_sum_reg;
    logic [SUM_W-1:0]   row_sum_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [SUM_W-1:0]   column_sum_next;
    logic [SUM_W-1:0]   row_sum_next;
    logic [COUNT_W-1:0] count_next;
    logic [SIZE_W-1:0]  last_column;
    logic [SIZE_W-1:0]  last_row;
    logic               is_object;
    logic               row_end;
    logic               frame_end;
    logic               accept;

    // Index of the last column or row: zero acts as one, oversize clamps to the limit.
    function automatic logic [SIZE_W-1:0] last_index(input logic [SIZE_W-1:0] size,
                                                     input int limit);
        logic [SIZE_W-1:0] result;
        if (size == '0) begin
            result = '0;
        end else if ({{(32-SIZE_W){1'b0}}, size} > 32'(limit)) begin
            result = SIZE_W'(limit - 1);
        end else begin
            result = size - SIZE_W'(1);
        end
        return result;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;

    assign last_column = last_index(frame_width_reg, MAX_WIDTH);
    assign last_row    = last_index(frame_height_reg, MAX_HEIGHT);

    assign is_object = (s_pixel == OBJECT_VALUE);
    assign row_end   = ({1'b0, column_reg} >= last_column);
    assign frame_end = row_end && ({1'b0, row_reg} >= last_row);

    always_comb begin
        column_sum_next = column_sum_reg;
        row_sum_next    = row_sum_reg;
        count_next      = count_reg;
        if (is_object) begin
            column_sum_next = column_sum_reg + {{(SUM_W-POS_W){1'b0}}, column_reg};
            row_sum_next    = row_sum_reg + {{(SUM_W-POS_W){1'b0}}, row_reg};
            count_next      = count_reg + COUNT_W'(1);
        end
    end

    assign push.valid            = accept && frame_end;
    assign push.sums.column_sum  = column_sum_next;
    assign push.sums.row_sum     = row_sum_next;
    assign push.sums.pixel_count = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            row_reg        <= '0;
            column_sum_reg <= '0;
            row_sum_reg    <= '0;
            count_reg      <= '0;
        end else if (accept) begin
            if (frame_end) begin
                column_reg     <= '0;
                row_reg        <= '0;
                column_sum_reg <= '0;
                row_sum_reg    <= '0;
                count_reg      <= '0;
            end else begin
                column_sum_reg <= column_sum_next;
                row_sum_reg    <= row_sum_next;
                count_reg      <= count_next;
                if (row_end) begin
                    column_reg <= '0;
                    row_reg    <= row_reg + POS_W'(1);
                end else begin
                    column_reg <= column_reg + POS_W'(1);
                end
            end
        end
    end

endmodule

[design/bmc_queue.sv]
// Two-entry queue of finished frame sums between the front and back ends.
// Depends on bmc_pkg for the entry types.
module bmc_queue import bmc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  frame_entry_t push,
    output logic         full,
    output logic         not_empty,
    input  logic         pop,
    output frame_sums_t  head
);

    frame_sums_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;

    logic        do_push;
    logic        do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.sums;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

[design/bmc_back.sv]
// Back end of the centroid core: two restoring dividers and the result register.
// Depends on bmc_pkg; takes frame sums from bmc_queue.
module bmc_back import bmc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                queue_not_empty,
    input  frame_sums_t         queue_head,
    output logic                queue_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COORD_W-1:0]  m_centroid_x,
    output logic [COORD_W-1:0]  m_centroid_y,
    output logic [COUNT_W-1:0]  m_object_pixels,
    output logic                m_no_object
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } back_state_t;

    back_state_t        state_reg;
    logic [SUM_W-1:0]   quot_x_reg;
    logic [SUM_W-1:0]   quot_y_reg;
    logic [COUNT_W-1:0] rem_x_reg;
    logic [COUNT_W-1:0] rem_y_reg;
    logic [COUNT_W-1:0] divisor_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               m_valid_reg;
    logic [COORD_W-1:0] centroid_x_reg;
    logic [COORD_W-1:0] centroid_y_reg;
    logic [COUNT_W-1:0] object_pixels_reg;
    logic               no_object_reg;

    logic [REM_W-1:0]   shift_x;
    logic [REM_W-1:0]   shift_y;
    logic [REM_W:0]     diff_x;
    logic [REM_W:0]     diff_y;
    logic               ge_x;
    logic               ge_y;
    logic [SUM_W-1:0]   quot_x_next;
    logic [SUM_W-1:0]   quot_y_next;
    logic [COUNT_W-1:0] rem_x_next;
    logic [COUNT_W-1:0] rem_y_next;

    // The dividend shifts out of the top while quotient bits shift in at the bottom.
    always_comb begin
        shift_x     = {rem_x_reg, quot_x_reg[SUM_W-1]};
        shift_y     = {rem_y_reg, quot_y_reg[SUM_W-1]};
        diff_x      = {1'b0, shift_x} - {2'b00, divisor_reg};
        diff_y      = {1'b0, shift_y} - {2'b00, divisor_reg};
        ge_x        = !diff_x[REM_W];
        ge_y        = !diff_y[REM_W];
        rem_x_next  = ge_x ? diff_x[COUNT_W-1:0] : shift_x[COUNT_W-1:0];
        rem_y_next  = ge_y ? diff_y[COUNT_W-1:0] : shift_y[COUNT_W-1:0];
        quot_x_next = {quot_x_reg[SUM_W-2:0], ge_x};
        quot_y_next = {quot_y_reg[SUM_W-2:0], ge_y};
    end

    assign queue_pop       = (state_reg == ST_IDLE) && queue_not_empty;
    assign m_valid         = m_valid_reg;
    assign m_centroid_x    = centroid_x_reg;
    assign m_centroid_y    = centroid_y_reg;
    assign m_object_pixels = object_pixels_reg;
    assign m_no_object     = no_object_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (queue_not_empty) begin
                        quot_x_reg        <= queue_head.column_sum;
                        quot_y_reg        <= queue_head.row_sum;
                        rem_x_reg         <= '0;
                        rem_y_reg         <= '0;
                        divisor_reg       <= queue_head.pixel_count;
                        object_pixels_reg <= queue_head.pixel_count;
                        step_reg          <= '0;
                        if (queue_head.pixel_count == '0) begin
                            centroid_x_reg <= '0;
                            centroid_y_reg <= '0;
                            no_object_reg  <= 1'b1;
                            m_valid_reg    <= 1'b1;
                            state_reg      <= ST_HOLD;
                        end else begin
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    quot_x_reg <= quot_x_next;
                    quot_y_reg <= quot_y_next;
                    rem_x_reg  <= rem_x_next;
                    rem_y_reg  <= rem_y_next;
                    step_reg   <= step_reg + STEP_W'(1);
                    if (step_reg == DIV_LAST_STEP) begin
                        centroid_x_reg <= quot_x_next[COORD_W-1:0];
                        centroid_y_reg <= quot_y_next[COORD_W-1:0];
                        no_object_reg  <= 1'b0;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/binary_mask_centroid_core.sv]
// Centroid of a binary mask frame: accepts one pixel per cycle while the sums queue has room.
// A frame's result follows its last accepted pixel through the sums queue, the load and the
// divide steps (an empty frame skips the divide); the shared restoring dividers give one
// quotient bit per step, and a new frame starts only after the last result is taken.
// A two-entry queue of frame sums lets short frames back up; the input stalls when it is full.
// Synchronous active-low reset: size registers return to 640 x 480, counters and sums clear.
module binary_mask_centroid_core import bmc_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIXEL_W-1:0]  s_pixel,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [SIZE_W-1:0]   cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COORD_W-1:0]  m_centroid_x,
    output logic [COORD_W-1:0]  m_centroid_y,
    output logic [COUNT_W-1:0]  m_object_pixels,
    output logic                m_no_object
);

    frame_entry_t push;
    frame_sums_t  queue_head;
    logic         queue_full;
    logic         queue_not_empty;
    logic         queue_pop;

    bmc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push)
    );

    bmc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop       (queue_pop),
        .head      (queue_head)
    );

    bmc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .queue_not_empty (queue_not_empty),
        .queue_head      (queue_head),
        .queue_pop       (queue_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_centroid_x    (m_centroid_x),
        .m_centroid_y    (m_centroid_y),
        .m_object_pixels (m_object_pixels),
        .m_no_object     (m_no_object)
    );

endmodule

[design/bmc_checker.sv]
// Port-level checks for the centroid core, bound to its top level.
// Depends on bmc_pkg and binary_mask_centroid_core_defines.svh.
`include "binary_mask_centroid_core_defines.svh"

module bmc_checker import bmc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [COORD_W-1:0]  m_centroid_x,
    input logic [COORD_W-1:0]  m_centroid_y,
    input logic [COUNT_W-1:0]  m_object_pixels,
    input logic                m_no_object
);

    logic [2*COORD_W+COUNT_W:0] result_bits;
    logic                       all_zero;

    assign result_bits = {m_centroid_x, m_centroid_y, m_object_pixels, m_no_object};
    assign all_zero    = (m_centroid_x == '0) && (m_centroid_y == '0) && (m_object_pixels == '0);

    // A result waiting on the sink keeps every field.
    `BMC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(result_bits))

    // An empty frame reports zero coordinates and a zero count.
    `BMC_ASSERT_SAME(a_empty_frame_zero, aclk, aresetn, m_valid && m_no_object, all_zero)

    // The no-object flag agrees with the count.
    `BMC_ASSERT_SAME(a_count_matches_flag, aclk, aresetn, m_valid && !m_no_object, m_object_pixels != '0)

endmodule

bind binary_mask_centroid_core bmc_checker u_bmc_checker (.*);

[verif/binary_mask_centroid_core_tb.sv]
// Self-checking testbench for binary_mask_centroid_core: streams mask frames of many sizes,
// predicts each frame's centroid, pixel count and empty flag, and checks every result.
// Depends on bmc_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmc_pkg::*;

    localparam int FRAME_MAX_W    = 2048;
    localparam int FRAME_MAX_H    = 2048;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [COORD_W-1:0] centroid_x;
        logic [COORD_W-1:0] centroid_y;
        logic [COUNT_W-1:0] object_pixels;
        logic               no_object;
    } centroid_t;

    class frame_centroid_tracker;
        logic [SIZE_W-1:0]  width_reg;
        logic [SIZE_W-1:0]  height_reg;
        logic [POS_W-1:0]   column_pos;
        logic [POS_W-1:0]   row_pos;
        logic [SUM_W-1:0]   column_total;
        logic [SUM_W-1:0]   row_total;
        logic [COUNT_W-1:0] object_count;
        centroid_t          expected_centroids[$];

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            column_pos = '0;
            row_pos = '0;
            column_total = '0;
            row_total = '0;
            object_count = '0;
        endfunction

        // A size of zero behaves as one; anything past the maximum is clamped.
        function int unsigned active_size(logic [SIZE_W-1:0] value, int unsigned limit);
            if (value == '0) return 1;
            if (value > limit) return limit;
            return value;
        endfunction

        function void write_register(logic idx, logic [SIZE_W-1:0] value);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int pending();
            return expected_centroids.size();
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px);
            int unsigned w;
            int unsigned h;
            bit          row_end;
            bit          frame_end;
            centroid_t   res;
            w = active_size(width_reg, FRAME_MAX_W);
            h = active_size(height_reg, FRAME_MAX_H);
            if (px == OBJECT_VALUE) begin
                column_total += SUM_W'(column_pos);
                row_total += SUM_W'(row_pos);
                object_count += 1'b1;
            end
            // Position checks use "at or past" so a size shrunk mid-frame ends it early.
            row_end = column_pos >= w - 1;
            frame_end = row_end && (row_pos >= h - 1);
            if (frame_end) begin
                if (object_count == '0) begin
                    res = '{centroid_x: '0, centroid_y: '0, object_pixels: '0, no_object: 1'b1};
                end else begin
                    res.centroid_x = COORD_W'(column_total / SUM_W'(object_count));
                    res.centroid_y = COORD_W'(row_total / SUM_W'(object_count));
                    res.object_pixels = object_count;
                    res.no_object = 1'b0;
                end
                expected_centroids.push_back(res);
                clear_frame();
            end else if (row_end) begin
                column_pos = '0;
                row_pos += 1'b1;
            end else begin
                column_pos += 1'b1;
            end
        endfunction

        function string check_centroid(centroid_t got);
            centroid_t want;
            if (expected_centroids.size() == 0) begin
                return $sformatf("unexpected frame result x=%0d y=%0d pixels=%0d empty=%0b",
                                 got.centroid_x, got.centroid_y, got.object_pixels,
                                 got.no_object);
            end
            want = expected_centroids.pop_front();
            if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
                    got.object_pixels !== want.object_pixels ||
                    got.no_object !== want.no_object) begin
                return $sformatf({"frame result x=%0d y=%0d pixels=%0d empty=%0b, ",
                                  "predicted x=%0d y=%0d pixels=%0d empty=%0b"},
                                 got.centroid_x, got.centroid_y, got.object_pixels,
                                 got.no_object, want.centroid_x, want.centroid_y,
                                 want.object_pixels, want.no_object);
            end
            return "";
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [PIXEL_W-1:0] s_pixel = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = REG_FRAME_WIDTH;
    logic [SIZE_W-1:0]  cfg_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COORD_W-1:0] m_centroid_x;
    logic [COORD_W-1:0] m_centroid_y;
    logic [COUNT_W-1:0] m_object_pixels;
    logic               m_no_object;

    bit in_steady = 1'b0;
    bit out_steady = 1'b0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    frame_centroid_tracker tracker = new();

    binary_mask_centroid_core #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_centroid_x    (m_centroid_x),
        .m_centroid_y    (m_centroid_y),
        .m_object_pixels (m_object_pixels),
        .m_no_object     (m_no_object)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Valid is only lowered when a gap is drawn, so back-to-back requests keep it high.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_pixel(px);
    endtask

    task automatic write_size(input logic idx, input logic [SIZE_W-1:0] value);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_register(idx, value);
    endtask

    task automatic configure(input bit set_w, input bit set_h,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        if (set_w) write_size(REG_FRAME_WIDTH, w);
        if (set_h) write_size(REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Stops input, waits until every pending frame result has been checked, then lets the bench settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [PIXEL_W-1:0] draw_pixel(input int density);
        if (density < 0) return PIXEL_W'($urandom_range(0, 254));
        if ($urandom_range(1, 100) <= density) return OBJECT_VALUE;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    initial begin : result_sink
        int        stall;
        centroid_t got;
        string     why;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = out_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.centroid_x = m_centroid_x;
            got.centroid_y = m_centroid_y;
            got.object_pixels = m_object_pixels;
            got.no_object = m_no_object;
            why = tracker.check_centroid(got);
            if (why != "") report_mismatch(why);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [PIXEL_W-1:0] corner_pixels[8] = '{8'hFF, 8'h00, 8'h55, 8'hAA,
                                                 8'h7F, 8'h80, 8'h01, 8'hFE};
        logic [PIXEL_W-1:0] shaped_frame[6] = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h3C, 8'hFF};
        int random_items;
        int frames;
        int count;
        int w_reg;
        int h_reg;
        int density;
        int area;
        bit set_w;
        bit set_h;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero sizes act as 1 x 1, so every pixel closes a frame, empty or not.
        configure(1'b1, 1'b1, '0, '0);
        foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
        drain();

        configure(1'b1, 1'b1, 12'd3, 12'd2);
        foreach (shaped_frame[i]) send_pixel(shaped_frame[i]);
        drain();

        // Shrink the frame while one is half done: it must close at the first fitting pixel.
        configure(1'b1, 1'b1, 12'd4, 12'd3);
        repeat (5) send_pixel(OBJECT_VALUE);
        drain();
        configure(1'b1, 1'b1, 12'd2, 12'd2);
        repeat (3) send_pixel(OBJECT_VALUE);
        drain();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            in_steady = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            w_reg = ($urandom_range(0, 7) == 0) ? 0 :
                    $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
            h_reg = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            set_w = ($urandom_range(0, 3) != 0);
            set_h = ($urandom_range(0, 3) != 0);
            configure(set_w, set_h, SIZE_W'(w_reg), SIZE_W'(h_reg));

            case ($urandom_range(0, 4))
                0: density = -1;
                1: density = 10;
                2: density = 50;
                3: density = 90;
                default: density = 100;
            endcase
            area = tracker.active_size(tracker.width_reg, FRAME_MAX_W) *
                   tracker.active_size(tracker.height_reg, FRAME_MAX_H);
            frames = $urandom_range(1, 6);
            count = frames * area;
            // Sometimes stop inside a frame so the next size change lands mid-frame.
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
            // The last batch is cut to the item budget; a cut frame carries into the next size.
            if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;

            repeat (count) send_pixel(draw_pixel(density));
            drain();
            random_items += count;
        end

        in_steady = 1'b0;
        out_steady = 1'b0;
        drain();
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
